[hw/rtl/jkse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkse_pkg
// Shared types and constants of the JSON key / string value extractor.
// ----------------------------------------------------------------------------
package jkse_pkg;

    // Longest key that can match, and the window depth the compare looks at
    localparam int MAX_KEY_CHARS = 32;
    localparam int WIN_DEPTH     = MAX_KEY_CHARS + 1;

    // Configuration register indexes (byte address is 8 * index)
    localparam logic [2:0] REG_KEY_LENGTH  = 3'd0;
    localparam logic [2:0] REG_KEY_CHARS_A = 3'd1;
    localparam logic [2:0] REG_KEY_CHARS_B = 3'd2;
    localparam logic [2:0] REG_KEY_CHARS_C = 3'd3;
    localparam logic [2:0] REG_KEY_CHARS_D = 3'd4;
    localparam logic [2:0] REG_OUT_LIMIT   = 3'd5;

    localparam logic [7:0] OUT_LIMIT_RESET = 8'hFF;

    // Characters the parser reacts to
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Bytes dropped after \u
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_COLON  = 3'd1,
        PH_QUOTE  = 3'd2,
        PH_STRING = 3'd3,
        PH_ESCAPE = 3'd4,
        PH_HEX    = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    // Per-item actions decoded from the phase and the byte
    typedef struct packed {
        logic       emit;
        logic [7:0] ch;
        logic       fin;
        logic       ok;
        logic       shift;
        logic       restart;
        logic       hex_load;
        logic       hex_dec;
        logic       silent;
    } action_t;

endpackage

[hw/rtl/json_key_string_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_key_string_extractor
// Searches a byte stream for "key" : "value" and streams the decoded value.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata           | tlast        | tuser
//  s_*      | in  | text_byte       | end_of_text  | -
//  m_*      | out | out_char        | finished     | [0] char_valid, [1] success
//  apb      | in  | 64-bit register access, register i at byte address 8*i
//
//  One item per cycle while results are taken. From acceptance to result an
//  item passes an input register, one pass of compare and decode logic, a result register.
//  The key compare is a parallel match of the window against the key.
//  Reset clears the window and the parser and handshake state; no clearing pass is needed.
//  A stalled result holds the input register; the input side keeps taking
//  items as long as the result register is free or being taken.
// ----------------------------------------------------------------------------
module json_key_string_extractor (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] char_valid, [1] success
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [5:0]  key_length_reg;
    logic [63:0] key_chars_a_reg;
    logic [63:0] key_chars_b_reg;
    logic [63:0] key_chars_c_reg;
    logic [63:0] key_chars_d_reg;
    logic [7:0]  out_limit_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[5:3];

    // Write a register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg  <= '0;
            key_chars_a_reg <= '0;
            key_chars_b_reg <= '0;
            key_chars_c_reg <= '0;
            key_chars_d_reg <= '0;
            out_limit_reg   <= jkse_pkg::OUT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                jkse_pkg::REG_KEY_LENGTH:  key_length_reg  <= pwdata[5:0];
                jkse_pkg::REG_KEY_CHARS_A: key_chars_a_reg <= pwdata;
                jkse_pkg::REG_KEY_CHARS_B: key_chars_b_reg <= pwdata;
                jkse_pkg::REG_KEY_CHARS_C: key_chars_c_reg <= pwdata;
                jkse_pkg::REG_KEY_CHARS_D: key_chars_d_reg <= pwdata;
                jkse_pkg::REG_OUT_LIMIT:   out_limit_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (cfg_index)
            jkse_pkg::REG_KEY_LENGTH:  prdata = {58'd0, key_length_reg};
            jkse_pkg::REG_KEY_CHARS_A: prdata = key_chars_a_reg;
            jkse_pkg::REG_KEY_CHARS_B: prdata = key_chars_b_reg;
            jkse_pkg::REG_KEY_CHARS_C: prdata = key_chars_c_reg;
            jkse_pkg::REG_KEY_CHARS_D: prdata = key_chars_d_reg;
            jkse_pkg::REG_OUT_LIMIT:   prdata = {56'd0, out_limit_reg};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------------
    jkse_pkg::phase_t phase_reg;
    jkse_pkg::phase_t phase_next;
    jkse_pkg::phase_t phase_step;
    logic [7:0]  window_reg [jkse_pkg::WIN_DEPTH];
    logic [5:0]  bytes_since_restart_reg;
    logic [5:0]  bytes_since_restart_next;
    logic [2:0]  hex_skip_left_reg;
    logic [2:0]  hex_skip_left_next;
    logic [2:0]  hex_dec_value;
    logic [7:0]  chars_emitted_reg;
    logic [7:0]  chars_emitted_next;

    logic [7:0]   c;
    logic         last;
    logic         is_ws;
    logic         is_ctrl_esc;
    logic [255:0] key_vec;
    logic         key_fits;
    logic         head_quote;
    logic         body_match;
    logic         len_ok;
    logic         key_match;
    logic [6:0]   plen;
    logic [6:0]   count_after;
    logic [5:0]   kidx;

    jkse_pkg::action_t act;
    logic        emit_final;
    logic        fin_final;
    logic        restart_final;
    logic        has_result;

    assign c    = in_byte_reg;
    assign last = in_last_reg;

    assign is_ws = (c == jkse_pkg::CH_SPACE) || (c == jkse_pkg::CH_TAB)
                || (c == jkse_pkg::CH_CR) || (c == jkse_pkg::CH_LF);
    assign is_ctrl_esc = (c == jkse_pkg::CH_LOW_N) || (c == jkse_pkg::CH_LOW_R)
                      || (c == jkse_pkg::CH_LOW_T) || (c == jkse_pkg::CH_LOW_B)
                      || (c == jkse_pkg::CH_LOW_F);

    assign key_vec = {key_chars_d_reg, key_chars_c_reg, key_chars_b_reg, key_chars_a_reg};

    // Compare the window, shifted by the new byte, with '"' key '"'.
    // Old window byte m lines up with key character key_length-1-m, and the
    // opening quote sits at old byte key_length.
    always_comb
    begin
        head_quote = 1'b0;
        body_match = 1'b1;
        kidx       = '0;
        for (int m = 0; m < jkse_pkg::WIN_DEPTH; m++)
        begin
            if (6'(m) == key_length_reg)
            begin
                head_quote = (window_reg[m] == jkse_pkg::CH_QUOTE);
            end
        end
        for (int m = 0; m < jkse_pkg::MAX_KEY_CHARS; m++)
        begin
            kidx = key_length_reg - 6'(m) - 6'd1;
            if (6'(m) < key_length_reg)
            begin
                if (window_reg[m] != key_vec[{kidx[4:0], 3'b000} +: 8])
                begin
                    body_match = 1'b0;
                end
            end
        end
    end

    assign key_fits    = (key_length_reg <= 6'(jkse_pkg::MAX_KEY_CHARS));
    assign plen        = {1'b0, key_length_reg} + 7'd2;
    assign count_after = (bytes_since_restart_reg == 6'h3F)
                       ? 7'd63 : {1'b0, bytes_since_restart_reg} + 7'd1;
    assign len_ok      = (count_after >= plen);
    assign key_match   = key_fits && len_ok && head_quote && body_match
                      && (c == jkse_pkg::CH_QUOTE);

    // Phase transition for the current byte, before end of text is applied
    always_comb
    begin
        phase_step    = phase_reg;
        hex_dec_value = (hex_skip_left_reg != 3'd0) ? hex_skip_left_reg - 3'd1 : 3'd0;
        unique case (phase_reg)
            jkse_pkg::PH_SEARCH:
            begin
                if (c != jkse_pkg::CH_NUL && key_match)
                    phase_step = jkse_pkg::PH_COLON;
            end
            jkse_pkg::PH_COLON:
            begin
                if (c == jkse_pkg::CH_COLON)
                    phase_step = jkse_pkg::PH_QUOTE;
                else if (!is_ws)
                    phase_step = jkse_pkg::PH_SEARCH;
            end
            jkse_pkg::PH_QUOTE:
            begin
                if (c == jkse_pkg::CH_QUOTE)
                    phase_step = jkse_pkg::PH_STRING;
            end
            jkse_pkg::PH_STRING:
            begin
                if (c == jkse_pkg::CH_BSLASH && !last)
                    phase_step = jkse_pkg::PH_ESCAPE;
            end
            jkse_pkg::PH_ESCAPE:
            begin
                if (c == jkse_pkg::CH_LOW_U)
                    phase_step = jkse_pkg::PH_HEX;
                else if (c != jkse_pkg::CH_NUL)
                    phase_step = jkse_pkg::PH_STRING;
            end
            jkse_pkg::PH_HEX:
            begin
                if (c != jkse_pkg::CH_NUL && hex_dec_value == 3'd0)
                    phase_step = jkse_pkg::PH_STRING;
            end
            default:
            begin
                phase_step = jkse_pkg::PH_DONE;
            end
        endcase
    end

    // Actions for the current byte
    always_comb
    begin
        act = '0;
        unique case (phase_reg)
            jkse_pkg::PH_SEARCH:
            begin
                if (c == jkse_pkg::CH_NUL)
                    act.fin = 1'b1;
                else
                    act.shift = 1'b1;
            end
            jkse_pkg::PH_COLON:
            begin
                if (c != jkse_pkg::CH_COLON && !is_ws)
                    act.restart = 1'b1;
            end
            jkse_pkg::PH_QUOTE:
            begin
                if (c != jkse_pkg::CH_QUOTE && !is_ws)
                    act.fin = 1'b1;
            end
            jkse_pkg::PH_STRING:
            begin
                if (c == jkse_pkg::CH_QUOTE)
                begin
                    act.fin = 1'b1;
                    act.ok  = 1'b1;
                end
                else if (c == jkse_pkg::CH_NUL)
                begin
                    act.fin = 1'b1;
                end
                else if (c != jkse_pkg::CH_BSLASH || last)
                begin
                    act.emit = 1'b1;
                    act.ch   = c;
                end
            end
            jkse_pkg::PH_ESCAPE:
            begin
                act.emit = 1'b1;
                if (c == jkse_pkg::CH_NUL)
                begin
                    act.ch  = jkse_pkg::CH_BSLASH;
                    act.fin = 1'b1;
                end
                else if (is_ctrl_esc)
                begin
                    act.ch = jkse_pkg::CH_SPACE;
                end
                else if (c == jkse_pkg::CH_LOW_U)
                begin
                    act.ch       = jkse_pkg::CH_QMARK;
                    act.hex_load = 1'b1;
                end
                else
                begin
                    act.ch = c;
                end
            end
            jkse_pkg::PH_HEX:
            begin
                if (c == jkse_pkg::CH_NUL)
                    act.fin = 1'b1;
                else
                    act.hex_dec = 1'b1;
            end
            default:
            begin
                // Finished: drop bytes until the end of the text
                act.silent  = 1'b1;
                act.restart = last;
            end
        endcase
    end

    // Apply end of text, the output limit and the restart
    always_comb
    begin
        fin_final     = !act.silent && (act.fin || last);
        emit_final    = act.emit && (chars_emitted_reg < out_limit_reg);
        restart_final = act.restart || (fin_final && last);
        has_result    = emit_final || fin_final;

        if (restart_final)
            phase_next = jkse_pkg::PH_SEARCH;
        else if (fin_final)
            phase_next = jkse_pkg::PH_DONE;
        else
            phase_next = phase_step;

        if (restart_final)
            bytes_since_restart_next = '0;
        else if (act.shift)
            bytes_since_restart_next = count_after[5:0];
        else
            bytes_since_restart_next = bytes_since_restart_reg;

        if (restart_final)
            hex_skip_left_next = '0;
        else if (act.hex_load)
            hex_skip_left_next = jkse_pkg::HEX_DIGITS;
        else if (act.hex_dec)
            hex_skip_left_next = hex_dec_value;
        else
            hex_skip_left_next = hex_skip_left_reg;

        if (restart_final)
            chars_emitted_next = '0;
        else if (emit_final)
            chars_emitted_next = chars_emitted_reg + 8'd1;
        else
            chars_emitted_next = chars_emitted_reg;
    end

    // Advance the parser state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg               <= jkse_pkg::PH_SEARCH;
            bytes_since_restart_reg <= '0;
            hex_skip_left_reg       <= '0;
            chars_emitted_reg       <= '0;
            for (int m = 0; m < jkse_pkg::WIN_DEPTH; m++)
                window_reg[m] <= '0;
        end
        else if (advance)
        begin
            phase_reg               <= phase_next;
            bytes_since_restart_reg <= bytes_since_restart_next;
            hex_skip_left_reg       <= hex_skip_left_next;
            chars_emitted_reg       <= chars_emitted_next;
            if (restart_final)
            begin
                for (int m = 0; m < jkse_pkg::WIN_DEPTH; m++)
                    window_reg[m] <= '0;
            end
            else if (act.shift)
            begin
                window_reg[0] <= c;
                for (int m = 1; m < jkse_pkg::WIN_DEPTH; m++)
                    window_reg[m] <= window_reg[m - 1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    logic [7:0] out_char_reg;
    logic       char_valid_reg;
    logic       finished_reg;
    logic       success_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= has_result;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold the result payload until the next item replaces it
    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            char_valid_reg <= emit_final;
            out_char_reg   <= emit_final ? act.ch : 8'd0;
            finished_reg   <= fin_final;
            success_reg    <= fin_final && act.ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = finished_reg;
    assign m_tuser  = {success_reg, char_valid_reg};

endmodule

[test/json_key_string_extractor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_key_string_extractor_checker
// Watches the input, result and register channels of the extractor, runs a
// cycle-free model of the key search and string decode on every accepted
// input item, and compares each accepted result item in order.
// ----------------------------------------------------------------------------
module json_key_string_extractor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_char
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,   // [0] char_valid, [1] success
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          due_count
);

    import jkse_pkg::*;

    // Window holds the quotes around the longest key
    localparam int WINDOW_LEN = MAX_KEY_CHARS + 2;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       finished;
        logic       success;
    } value_result_t;

    value_result_t results_due[$];
    value_result_t want;
    int            mismatches = 0;

    // Shadow registers
    logic [5:0]  key_len_q;
    logic [63:0] key_words [0:3];
    logic [7:0]  out_limit_q;

    // Parser state
    logic [7:0]  window_q [0:WINDOW_LEN-1];
    logic [5:0]  fill_count;
    phase_t      phase_q;
    logic [2:0]  hex_left;
    logic [7:0]  emitted;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [7:0] key_byte(input int k);
        if (k >= 32)
            return CH_NUL;
        return key_words[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    // Compare the newest key_len+2 bytes against "key"
    function automatic logic key_hit();
        int         plen;
        int         i;
        logic [7:0] pat;
        if (key_len_q > MAX_KEY_CHARS)
            return 1'b0;
        plen = key_len_q + 2;
        if (fill_count < plen)
            return 1'b0;
        for (i = 0; i < plen; i++)
        begin
            pat = (i == 0 || i == plen - 1) ? CH_QUOTE : key_byte(i - 1);
            if (window_q[plen - 1 - i] != pat)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic restart_search();
        int i;
        for (i = 0; i < WINDOW_LEN; i++)
            window_q[i] = CH_NUL;
        fill_count = '0;
        phase_q    = PH_SEARCH;
        hex_left   = '0;
        emitted    = '0;
    endtask

    // Advance the parser by one text byte and queue the result it causes
    task automatic parse_text_byte(input logic [7:0] c, input logic eot);
        logic          emit;
        logic          fin;
        logic          ok;
        logic          ignored;
        logic [7:0]    ch;
        int            i;
        value_result_t r;
        emit    = 1'b0;
        fin     = 1'b0;
        ok      = 1'b0;
        ignored = 1'b0;
        ch      = CH_NUL;
        case (phase_q)
            PH_SEARCH:
            begin
                if (c == CH_NUL)
                    fin = 1'b1;
                else
                begin
                    for (i = WINDOW_LEN - 1; i > 0; i--)
                        window_q[i] = window_q[i - 1];
                    window_q[0] = c;
                    if (fill_count != 6'd63)
                        fill_count = fill_count + 6'd1;
                    if (key_hit())
                        phase_q = PH_COLON;
                end
            end
            PH_COLON:
            begin
                if (c == CH_COLON)
                    phase_q = PH_QUOTE;
                else if (!is_space(c))
                    restart_search();
            end
            PH_QUOTE:
            begin
                if (c == CH_QUOTE)
                    phase_q = PH_STRING;
                else if (!is_space(c))
                    fin = 1'b1;
            end
            PH_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    fin = 1'b1;
                    ok  = 1'b1;
                end
                else if (c == CH_NUL)
                    fin = 1'b1;
                else if (c == CH_BSLASH)
                begin
                    // a backslash on the final byte is emitted as is
                    if (eot)
                    begin
                        emit = 1'b1;
                        ch   = c;
                    end
                    else
                        phase_q = PH_ESCAPE;
                end
                else
                begin
                    emit = 1'b1;
                    ch   = c;
                end
            end
            PH_ESCAPE:
            begin
                emit = 1'b1;
                if (c == CH_NUL)
                begin
                    ch  = CH_BSLASH;
                    fin = 1'b1;
                end
                else if (c == CH_LOW_N || c == CH_LOW_R || c == CH_LOW_T ||
                         c == CH_LOW_B || c == CH_LOW_F)
                begin
                    ch      = CH_SPACE;
                    phase_q = PH_STRING;
                end
                else if (c == CH_LOW_U)
                begin
                    ch       = CH_QMARK;
                    hex_left = HEX_DIGITS;
                    phase_q  = PH_HEX;
                end
                else
                begin
                    ch      = c;
                    phase_q = PH_STRING;
                end
            end
            PH_HEX:
            begin
                if (c == CH_NUL)
                    fin = 1'b1;
                else
                begin
                    if (hex_left != 3'd0)
                        hex_left = hex_left - 3'd1;
                    if (hex_left == 3'd0)
                        phase_q = PH_STRING;
                end
            end
            default:
            begin
                // finished: drop bytes until the end of the text
                ignored = 1'b1;
                if (eot)
                    restart_search();
            end
        endcase

        if (!ignored)
        begin
            if (eot)
                fin = 1'b1;
            if (emit)
            begin
                if (emitted < out_limit_q)
                    emitted = emitted + 8'd1;
                else
                    emit = 1'b0;
            end
            if (fin)
            begin
                if (eot)
                    restart_search();
                else
                    phase_q = PH_DONE;
            end
            if (emit || fin)
            begin
                r.char_valid = emit;
                r.out_char   = emit ? ch : CH_NUL;
                r.finished   = fin;
                r.success    = fin && ok;
                results_due.push_back(r);
            end
        end
    endtask

    // Compare results, predict inputs, track register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_q    = '0;
            key_words[0] = '0;
            key_words[1] = '0;
            key_words[2] = '0;
            key_words[3] = '0;
            out_limit_q  = OUT_LIMIT_RESET;
            restart_search();
            results_due.delete();
            due_count  <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: out_char %02h char_valid %0b finished %0b",
                           m_tdata, m_tuser[0], m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (m_tuser[0] !== want.char_valid)
                    begin
                        $error("char_valid mismatch: expected %0b, actual %0b",
                               want.char_valid, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tdata !== want.out_char)
                    begin
                        $error("out_char mismatch: expected %02h, actual %02h",
                               want.out_char, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.finished)
                    begin
                        $error("finished mismatch: expected %0b, actual %0b",
                               want.finished, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser[1] !== want.success)
                    begin
                        $error("success mismatch: expected %0b, actual %0b",
                               want.success, m_tuser[1]);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                parse_text_byte(s_tdata, s_tlast);

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_KEY_LENGTH:  key_len_q    = pwdata[5:0];
                    REG_KEY_CHARS_A: key_words[0] = pwdata;
                    REG_KEY_CHARS_B: key_words[1] = pwdata;
                    REG_KEY_CHARS_C: key_words[2] = pwdata;
                    REG_KEY_CHARS_D: key_words[3] = pwdata;
                    REG_OUT_LIMIT:   out_limit_q  = pwdata[7:0];
                    default: ;
                endcase
            end

            due_count  <= results_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

[test/tb_json_key_string_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_key_string_extractor
// Drives texts through the extractor under several key and limit settings:
// a few hand-written texts first, then random texts that are mostly
// well-formed "key": "value" pairs with random content and escapes, mixed
// with noise and broken pairs. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_json_key_string_extractor;

    import jkse_pkg::*;

    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         NUM_PHASES      = 9;
    localparam int         ITEMS_PER_PHASE = 90;
    localparam int         SETTLE_CYCLES   = 8;
    localparam logic [7:0] CH_ZERO         = 8'h30;
    localparam logic [7:0] CH_LOW_A        = 8'h61;
    localparam logic [7:0] CH_LOW_K        = 8'h6B;
    localparam logic [7:0] CH_TILDE        = 8'h7E;
    localparam logic [7:0] CH_ALL_ONES     = 8'hFF;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [5:0]  paddr    = 6'd0;
    logic [63:0] pwdata   = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          due_count;
    int          cycle_count = 0;
    int          seg_left    = 0;
    int          rx_mode     = 0;
    int          burst_left  = 0;
    int          bytes_sent  = 0;
    int          key_len;
    logic [7:0]  key_bytes [0:63];
    logic [7:0]  text_q[$];

    json_key_string_extractor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    json_key_string_extractor_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: segments of always ready, coin flip, sparse, near stall
    always @(posedge clk)
    begin
        if (seg_left == 0)
        begin
            rx_mode  <= $urandom_range(0, 3);
            seg_left <= $urandom_range(8, 150);
            m_tready <= 1'b1;
        end
        else
        begin
            seg_left <= seg_left - 1;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((seg_left & 15) == 0);
            endcase
        end
    end

    function automatic logic [7:0] space_byte();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Printable value character other than quote and backslash
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(CH_SPACE, CH_TILDE));
        if (c == CH_QUOTE || c == CH_BSLASH)
            c = CH_ZERO;
        return c;
    endfunction

    function automatic logic [7:0] hex_digit();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        return (v < 8'd10) ? CH_ZERO + v : CH_LOW_A + v - 8'd10;
    endfunction

    // Byte biased toward the characters the parser reacts to
    function automatic logic [7:0] noise_byte();
        int unsigned r;
        logic [7:0]  c;
        r = $urandom_range(0, 99);
        c = 8'($urandom_range(1, 255));
        if (r < 15)
            c = CH_QUOTE;
        else if (r < 23)
            c = CH_COLON;
        else if (r < 30)
            c = CH_BSLASH;
        else if (r < 38)
            c = space_byte();
        else if (r < 55 && key_len > 0)
            c = key_bytes[$urandom_range(0, key_len - 1)];
        else if (r < 57)
            c = CH_NUL;
        return c;
    endfunction

    function automatic logic [63:0] pack_key(input int base);
        logic [63:0] w;
        int          i;
        for (i = 0; i < 8; i++)
            w[i * 8 +: 8] = key_bytes[base + i];
        return w;
    endfunction

    task automatic queue_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // Offer one item, with a random gap in front of each burst
    task automatic push_item(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Send the queued text, end_of_text on its final byte
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++)
            push_item(text_q[i], i == text_q.size() - 1);
        bytes_sent = bytes_sent + text_q.size();
        text_q.delete();
    endtask

    // Hold off the sender until every expected result is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          p;
        int          k;
        int          target;
        int          n;
        int          i;
        int          j;
        int unsigned r;
        logic [7:0]  limit;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // Pick this phase's key and limit
            case (p)
                0:
                begin
                    key_len = 1;
                    limit   = OUT_LIMIT_RESET;
                end
                1:
                begin
                    key_len = 0;
                    limit   = CH_ALL_ONES;
                end
                2:
                begin
                    key_len = MAX_KEY_CHARS;
                    limit   = CH_ALL_ONES;
                end
                3:
                begin
                    key_len = $urandom_range(1, 8);
                    limit   = 8'd0;
                end
                4:
                begin
                    key_len = $urandom_range(1, 12);
                    limit   = 8'($urandom_range(1, 6));
                end
                5:
                begin
                    key_len = 63;
                    limit   = CH_ALL_ONES;
                end
                6:
                begin
                    key_len = $urandom_range(2, 31);
                    limit   = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    key_len = $urandom_range(1, 16);
                    limit   = 8'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 8)
                                                             : $urandom_range(9, 255));
                end
            endcase
            for (k = 0; k < 64; k++)
                key_bytes[k] = 8'($urandom_range(1, 255));
            if (p == 0)
                key_bytes[0] = CH_LOW_K;
            // a zero key character can never match
            if (p == 6)
                key_bytes[$urandom_range(0, key_len - 1)] = CH_NUL;

            apb_write(REG_KEY_LENGTH, 64'(key_len));
            apb_write(REG_KEY_CHARS_A, pack_key(0));
            apb_write(REG_KEY_CHARS_B, pack_key(8));
            apb_write(REG_KEY_CHARS_C, pack_key(16));
            apb_write(REG_KEY_CHARS_D, pack_key(24));
            apb_write(REG_OUT_LIMIT, {56'd0, limit});

            if (p == 0)
            begin
                // escapes, \u dropping a quote and an all-ones byte, close
                queue_str("\"k\":\"\\n\\u\"1");
                text_q.push_back(CH_ALL_ONES);
                queue_str("y\\q\"");
                send_text();
                // NUL while searching, then a byte ignored up to end of text
                text_q.push_back(CH_NUL);
                queue_str("Z");
                send_text();
                // wrong byte where the colon goes, then no opening quote
                queue_str("\"k\"x\"k\":5");
                send_text();
                // backslash on the final byte
                queue_str("\"k\":\"\\");
                send_text();
                drain_results();
            end

            target = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    // plain noise text
                    n = $urandom_range(1, 20);
                    for (i = 0; i < n; i++)
                        text_q.push_back(noise_byte());
                end
                else
                begin
                    n = $urandom_range(0, 4);
                    for (i = 0; i < n; i++)
                        text_q.push_back(noise_byte());
                    // "key", now and then with a byte or more off
                    text_q.push_back(CH_QUOTE);
                    for (i = 0; i < key_len && i < 40; i++)
                        text_q.push_back(($urandom_range(0, 99) < 5) ? noise_byte()
                                                                     : key_bytes[i]);
                    text_q.push_back(CH_QUOTE);
                    n = $urandom_range(0, 2);
                    for (i = 0; i < n; i++)
                        text_q.push_back(space_byte());
                    text_q.push_back(($urandom_range(0, 99) < 92) ? CH_COLON : noise_byte());
                    n = $urandom_range(0, 2);
                    for (i = 0; i < n; i++)
                        text_q.push_back(space_byte());
                    text_q.push_back(($urandom_range(0, 99) < 92) ? CH_QUOTE : noise_byte());
                    // value body
                    n = $urandom_range(0, 10);
                    for (i = 0; i < n; i++)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 70)
                            text_q.push_back(plain_byte());
                        else if (r < 90)
                        begin
                            text_q.push_back(CH_BSLASH);
                            case ($urandom_range(0, 8))
                                0:       text_q.push_back(CH_LOW_N);
                                1:       text_q.push_back(CH_LOW_R);
                                2:       text_q.push_back(CH_LOW_T);
                                3:       text_q.push_back(CH_LOW_B);
                                4:       text_q.push_back(CH_LOW_F);
                                5:       text_q.push_back(CH_QUOTE);
                                6:       text_q.push_back(CH_BSLASH);
                                7:
                                begin
                                    text_q.push_back(CH_LOW_U);
                                    for (j = 0; j < 4; j++)
                                    begin
                                        case ($urandom_range(0, 19))
                                            0:       text_q.push_back(CH_QUOTE);
                                            1:       text_q.push_back(CH_NUL);
                                            2:       text_q.push_back(noise_byte());
                                            default: text_q.push_back(hex_digit());
                                        endcase
                                    end
                                end
                                default: text_q.push_back(8'($urandom_range(1, 255)));
                            endcase
                        end
                        else if (r < 97)
                            text_q.push_back(8'($urandom_range(1, 255)));
                        else
                            text_q.push_back(CH_NUL);
                    end
                    // how the value ends
                    r = $urandom_range(0, 99);
                    if (r < 75)
                    begin
                        text_q.push_back(CH_QUOTE);
                        n = $urandom_range(0, 3);
                        for (i = 0; i < n; i++)
                            text_q.push_back(noise_byte());
                    end
                    else if (r < 92 && r >= 85)
                    begin
                        text_q.push_back(CH_NUL);
                        n = $urandom_range(0, 2);
                        for (i = 0; i < n; i++)
                            text_q.push_back(noise_byte());
                    end
                    else if (r >= 92)
                    begin
                        text_q.push_back(CH_BSLASH);
                        if ($urandom_range(0, 1) == 1)
                            text_q.push_back(CH_NUL);
                    end
                end
                send_text();
                if ($urandom_range(0, 24) == 0)
                    drain_results();
            end
            drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
